[rtl/bfsa_pkg.sv]
`default_nettype none
package bfsa_pkg;

    // map geometry
    localparam int MAP_ENTRIES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = MAP_ENTRIES / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int RAM_DEPTH   = 2 * MAP_WORDS;
    localparam int RAM_AW      = WORD_AW + 1;

    // field widths
    localparam int OP_W   = 3;
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CHECK = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_SET   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;

    // configuration register indexes
    localparam logic REG_INODE_COUNT = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    // map select codes
    localparam logic MAP_BLOCKS = 1'b0;
    localparam logic MAP_INODES = 1'b1;

    // word scan request and response
    typedef struct packed {
        logic [WORD_AW-1:0] word_num;
        logic [WORD_AW-1:0] last_word;
        logic [BIT_W-1:0]   last_bit;
    } scan_req_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_num;
    } scan_rsp_t;

endpackage
`default_nettype wire

[rtl/bfsa_ram.sv]
`default_nettype none
module bfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/bfsa_word_scan.sv]
`default_nettype none
module bfsa_word_scan (
    input  wire logic [bfsa_pkg::WORD_BITS-1:0] word_data,
    input  wire bfsa_pkg::scan_req_t            req,
    output bfsa_pkg::scan_rsp_t                 rsp
);
    import bfsa_pkg::*;

    logic [WORD_BITS-1:0] free_mask;
    logic                 below_last;

    // free entries inside the search window, entry zero excluded
    always_comb begin
        below_last = req.word_num < req.last_word;
        free_mask  = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            free_mask[b] = !word_data[b] && (below_last || (BIT_W'(b) <= req.last_bit));
        end
        if (req.word_num == '0) begin
            free_mask[0] = 1'b0;
        end
    end

    // lowest set bit
    always_comb begin
        rsp.hit     = |free_mask;
        rsp.bit_num = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_mask[b]) begin
                rsp.bit_num = BIT_W'(b);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/bitmap_free_space_allocator.sv]
`default_nettype none
// channel   ports                                           handshake
// -------   ---------------------------------------------   ---------------
// request   s_operation, s_map_select, s_entry_index        s_valid/s_ready
// response  m_status, m_in_use, m_found_index               m_valid/m_ready
// config    psel, penable, pwrite, paddr, pwdata, prdata    apb, pready = 1
//
// after reset the ram is swept to zero with s_ready low; check reads its word and
// responds, clear and set also write it back, ops 5..7 and requests refused at
// once respond directly; find reads one bitmap word per cycle through the shared
// word scan, allocate adds the write back; the one-port-each ram sets the pace
// a new request is taken only in idle; a response waits in its register
// while m_ready is low, and the next request may then be taken
module bitmap_free_space_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bfsa_pkg::OP_W-1:0]     s_operation,
    input  wire logic                          s_map_select,
    input  wire logic [bfsa_pkg::IDX_W-1:0]    s_entry_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bfsa_pkg::STAT_W-1:0]   m_status,
    output logic                               m_in_use,
    output logic      [bfsa_pkg::IDX_W-1:0]    m_found_index,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import bfsa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_SCAN,
        S_WRITE,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [RAM_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic                 map_reg, map_next;
    logic [WORD_AW-1:0]   word_reg, word_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [WORD_AW-1:0]   eval_word_reg, eval_word_next;
    logic [WORD_AW-1:0]   last_word_reg, last_word_next;
    logic [BIT_W-1:0]     last_bit_reg, last_bit_next;
    logic [WORD_BITS-1:0] wdata_reg, wdata_next;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic                 res_in_use_reg, res_in_use_next;
    logic [IDX_W-1:0]     res_found_reg, res_found_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]    m_status_reg, m_status_next;
    logic                 m_in_use_reg, m_in_use_next;
    logic [IDX_W-1:0]     m_found_reg, m_found_next;
    logic [CNT_W-1:0]     inode_count_reg, block_count_reg;

    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    scan_req_t            scan_req;
    scan_rsp_t            scan_rsp;

    logic [CNT_W-1:0]     sel_count;
    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     lim_m1;
    logic                 idx_in_range;
    logic                 search_none;
    logic [WORD_AW-1:0]   idx_word;
    logic                 cfg_write;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_count_reg <= CNT_W'(MAP_ENTRIES);
            block_count_reg <= CNT_W'(MAP_ENTRIES);
        end else if (cfg_write) begin
            if (paddr[2] == REG_INODE_COUNT) begin
                inode_count_reg <= pwdata[CNT_W-1:0];
            end else begin
                block_count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? 32'(block_count_reg)
                                                  : 32'(inode_count_reg);

    // search window of the requested map
    always_comb begin
        sel_count    = (s_map_select == MAP_INODES) ? inode_count_reg : block_count_reg;
        lim          = (sel_count > CNT_W'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : sel_count;
        lim_m1       = lim - CNT_W'(1);
        idx_in_range = CNT_W'(s_entry_index) < lim;
        search_none  = lim <= CNT_W'(1);
        idx_word     = WORD_AW'(s_entry_index >> BIT_W);
    end

    // bitmap storage, both maps
    bfsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared word scan
    assign scan_req.word_num  = eval_word_reg;
    assign scan_req.last_word = last_word_reg;
    assign scan_req.last_bit  = last_bit_reg;

    bfsa_word_scan u_scan (
        .word_data (ram_rdata),
        .req       (scan_req),
        .rsp       (scan_rsp)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        op_next         = op_reg;
        map_next        = map_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        eval_word_next  = eval_word_reg;
        last_word_next  = last_word_reg;
        last_bit_next   = last_bit_reg;
        wdata_next      = wdata_reg;
        res_status_next = res_status_reg;
        res_in_use_next = res_in_use_reg;
        res_found_next  = res_found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_in_use_next   = m_in_use_reg;
        m_found_next    = m_found_reg;
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = {map_reg, word_reg};
        ram_wdata       = wdata_reg;
        ram_raddr       = {map_reg, word_reg};

        case (state_reg)
            S_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + RAM_AW'(1);
                if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = {s_map_select,
                             (s_operation == OP_FIND || s_operation == OP_ALLOC)
                                 ? WORD_AW'(0) : idx_word};
                if (s_valid) begin
                    op_next         = s_operation;
                    map_next        = s_map_select;
                    word_next       = idx_word;
                    bit_next        = s_entry_index[BIT_W-1:0];
                    eval_word_next  = '0;
                    last_word_next  = WORD_AW'(lim_m1 >> BIT_W);
                    last_bit_next   = lim_m1[BIT_W-1:0];
                    res_status_next = STAT_OK;
                    res_in_use_next = 1'b0;
                    res_found_next  = '0;
                    if (s_operation == OP_CHECK || s_operation == OP_CLEAR ||
                        s_operation == OP_SET) begin
                        if (idx_in_range) begin
                            state_next = S_ACCESS;
                        end else begin
                            res_status_next = STAT_RANGE;
                            state_next      = S_RESP;
                        end
                    end else if (s_operation == OP_FIND || s_operation == OP_ALLOC) begin
                        if (search_none) begin
                            res_status_next = STAT_NONE;
                            state_next      = S_RESP;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_ACCESS: begin
                wdata_next = ram_rdata;
                if (op_reg == OP_CHECK) begin
                    res_in_use_next = ram_rdata[bit_reg];
                    state_next      = S_RESP;
                end else begin
                    wdata_next[bit_reg] = (op_reg == OP_SET);
                    state_next          = S_WRITE;
                end
            end
            S_SCAN: begin
                // read of the next word overlaps the scan of this one
                ram_raddr      = {map_reg, eval_word_reg + WORD_AW'(1)};
                eval_word_next = eval_word_reg + WORD_AW'(1);
                if (scan_rsp.hit) begin
                    res_found_next = IDX_W'({eval_word_reg, scan_rsp.bit_num});
                    word_next      = eval_word_reg;
                    wdata_next     = ram_rdata;
                    wdata_next[scan_rsp.bit_num] = 1'b1;
                    state_next     = (op_reg == OP_ALLOC) ? S_WRITE : S_RESP;
                end else if (eval_word_reg == last_word_reg) begin
                    res_status_next = STAT_NONE;
                    state_next      = S_RESP;
                end
            end
            S_WRITE: begin
                ram_we     = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_in_use_next = res_in_use_reg;
                    m_found_next  = res_found_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            m_valid_reg    <= m_valid_next;
            op_reg         <= op_next;
            map_reg        <= map_next;
            word_reg       <= word_next;
            bit_reg        <= bit_next;
            eval_word_reg  <= eval_word_next;
            last_word_reg  <= last_word_next;
            last_bit_reg   <= last_bit_next;
            wdata_reg      <= wdata_next;
            res_status_reg <= res_status_next;
            res_in_use_reg <= res_in_use_next;
            res_found_reg  <= res_found_next;
            m_status_reg   <= m_status_next;
            m_in_use_reg   <= m_in_use_next;
            m_found_reg    <= m_found_next;
        end
    end

    // response channel
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_in_use      = m_in_use_reg;
    assign m_found_index = m_found_reg;

endmodule
`default_nettype wire
